// ----- src/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// srp_pkg
// Shared widths, codes and types of the segment relocation patcher.
// ----------------------------------------------------------------------------
package srp_pkg;

  // image memory address bits; the image is split into an even and an odd bank
  localparam int ADDR_BITS = 20;
  localparam int ROW_W     = ADDR_BITS - 1;

  localparam int SEG_W     = 16;
  localparam int OFF_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int BADDR_W   = 20;
  localparam int LIMIT_W   = 21;
  // physical addresses run up to 0x10FFEF
  localparam int PA_W      = 21;
  localparam int WIDE_W    = (ADDR_BITS > PA_W) ? ADDR_BITS : PA_W;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_SEG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PSP_SEG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_LIMIT = 2'd2;

  localparam logic [SEG_W-1:0]   LOAD_SEG_RST  = 16'd16;
  localparam logic [SEG_W-1:0]   PSP_SEG_RST   = 16'd0;
  localparam logic [LIMIT_W-1:0] RAM_LIMIT_RST = 21'd655360;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_RELOC = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RELOC_OOR = 2'd1;
  localparam logic [1:0] ST_ADDR_OOR  = 2'd2;

  // address decode handed from the address unit to the control
  typedef struct packed {
    logic [ROW_W-1:0] lo_row;
    logic [ROW_W-1:0] hi_row;
    logic             lo_odd;
    logic             reloc_ok;
    logic [ROW_W-1:0] byte_row;
    logic             byte_odd;
    logic             byte_ok;
  } srp_addr_t;

endpackage

// ----- src/srp_ifs.sv -----
// ----------------------------------------------------------------------------
// srp_ifs
// Valid/ready channels of the segment relocation patcher.
// ----------------------------------------------------------------------------
interface srp_in_if import srp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [BADDR_W-1:0] byte_address;
  logic [BYTE_W-1:0]  write_byte;
  logic [SEG_W-1:0]   rel_seg;
  logic [OFF_W-1:0]   rel_off;

  modport source (output valid, func, byte_address, write_byte, rel_seg,
                  rel_off, input ready);
  modport sink (input valid, func, byte_address, write_byte, rel_seg,
                rel_off, output ready);
endinterface

interface srp_out_if import srp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [BYTE_W-1:0] read_byte;

  modport source (output valid, status, read_byte, input ready);
  modport sink (input valid, status, read_byte, output ready);
endinterface

// ----- src/segment_relocation_patcher.sv -----
// ----------------------------------------------------------------------------
// segment_relocation_patcher
// Byte image memory with byte write/read and in-place segment relocation.
// ----------------------------------------------------------------------------
// Timing: relocation and byte read pass through a second state (S_PATCH or S_READ)
//   before the result register loads; byte write and rejected items load it on the transfer edge.
// Throughput: a relocation takes no new item until its read-then-write pass over the two
//   image banks is done; a byte write every cycle while the result is drained.
// Reset: clears the control FSM and the result valid, and loads the register
//   defaults; image memory keeps its contents (undefined until written).
// ----------------------------------------------------------------------------
module segment_relocation_patcher import srp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  srp_in_if.sink               in_ch,
  srp_out_if.source            out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PATCH
  } state_t;

  state_t state;

  // configuration registers
  logic [SEG_W-1:0]   load_seg;
  logic [SEG_W-1:0]   psp_seg;
  logic [LIMIT_W-1:0] ram_limit;

  // result register
  logic              out_valid;
  logic [1:0]        out_status;
  logic [BYTE_W-1:0] out_rbyte;
  logic              out_load;

  // per-item context carried into the S_READ or S_PATCH state
  logic [ROW_W-1:0] lo_row;
  logic [ROW_W-1:0] hi_row;
  logic             lo_odd;
  logic             byte_odd;

  srp_addr_t addr;

  logic             in_ready;
  logic             accept;

  logic             even_we;
  logic [ROW_W-1:0] even_waddr;
  logic [BYTE_W-1:0] even_wdata;
  logic [ROW_W-1:0] even_raddr;
  logic [BYTE_W-1:0] even_q;
  logic             odd_we;
  logic [ROW_W-1:0] odd_waddr;
  logic [BYTE_W-1:0] odd_wdata;
  logic [ROW_W-1:0] odd_raddr;
  logic [BYTE_W-1:0] odd_q;

  logic [BYTE_W-1:0] lo_q;
  logic [BYTE_W-1:0] hi_q;
  logic [SEG_W-1:0]  patch_word;

  // --------------------------------------------------------------------------
  // Config writes; index 3 is ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      load_seg  <= LOAD_SEG_RST;
      psp_seg   <= PSP_SEG_RST;
      ram_limit <= RAM_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOAD_SEG:  load_seg  <= cfg_wdata[SEG_W-1:0];
        CFG_PSP_SEG:   psp_seg   <= cfg_wdata[SEG_W-1:0];
        CFG_RAM_LIMIT: ram_limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Address forming straight off the input payload, so reads issue on the
  // transfer edge.
  // --------------------------------------------------------------------------
  srp_addr_gen u_addr_gen (
    .load_seg     (load_seg),
    .psp_seg      (psp_seg),
    .ram_limit    (ram_limit),
    .byte_address (in_ch.byte_address),
    .rel_seg      (in_ch.rel_seg),
    .rel_off      (in_ch.rel_off),
    .addr         (addr)
  );

  // Take a new item only when idle and the result slot is free (or draining
  // this cycle); items that finish on the transfer edge load it right away.
  assign in_ready     = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;

  // result gets loaded this edge: S_READ or S_PATCH state of a read or relocation, or
  // an item that completes on its transfer edge
  assign out_load = (state != S_IDLE) ||
                    (accept && !(in_ch.func == FN_READ && addr.byte_ok) &&
                     !(in_ch.func == FN_RELOC && addr.reloc_ok));

  // --------------------------------------------------------------------------
  // Bank access. Read addresses only matter on the transfer edge.
  // --------------------------------------------------------------------------
  always_comb begin
    if (in_ch.func == FN_RELOC) begin
      even_raddr = addr.lo_odd ? addr.hi_row : addr.lo_row;
      odd_raddr  = addr.lo_odd ? addr.lo_row : addr.hi_row;
    end else begin
      even_raddr = addr.byte_row;
      odd_raddr  = addr.byte_row;
    end
  end

  assign lo_q       = lo_odd ? odd_q : even_q;
  assign hi_q       = lo_odd ? even_q : odd_q;
  assign patch_word = {hi_q, lo_q} + load_seg;

  always_comb begin
    even_we    = 1'b0;
    odd_we     = 1'b0;
    even_waddr = addr.byte_row;
    odd_waddr  = addr.byte_row;
    even_wdata = in_ch.write_byte;
    odd_wdata  = in_ch.write_byte;
    if (state == S_PATCH) begin
      // patched word goes back as two bytes, one per bank
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_waddr = lo_odd ? hi_row : lo_row;
      odd_waddr  = lo_odd ? lo_row : hi_row;
      even_wdata = lo_odd ? patch_word[SEG_W-1:BYTE_W] : patch_word[BYTE_W-1:0];
      odd_wdata  = lo_odd ? patch_word[BYTE_W-1:0] : patch_word[SEG_W-1:BYTE_W];
    end else if (accept && in_ch.func == FN_WRITE && addr.byte_ok) begin
      even_we = !addr.byte_odd;
      odd_we  = addr.byte_odd;
    end
  end

  srp_ram #(.ADDR_W(ROW_W), .DATA_W(BYTE_W)) u_even_bank (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (accept),
    .raddr (even_raddr),
    .rdata (even_q)
  );

  srp_ram #(.ADDR_W(ROW_W), .DATA_W(BYTE_W)) u_odd_bank (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (accept),
    .raddr (odd_raddr),
    .rdata (odd_q)
  );

  // --------------------------------------------------------------------------
  // Control FSM and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lo_row   <= addr.lo_row;
            hi_row   <= addr.hi_row;
            lo_odd   <= addr.lo_odd;
            byte_odd <= addr.byte_odd;
            out_rbyte <= '0;
            case (in_ch.func)
              FN_WRITE: begin
                out_status <= addr.byte_ok ? ST_OK : ST_ADDR_OOR;
              end
              FN_READ: begin
                if (addr.byte_ok) begin
                  state <= S_READ;
                end else begin
                  out_status <= ST_ADDR_OOR;
                end
              end
              FN_RELOC: begin
                if (addr.reloc_ok) begin
                  state <= S_PATCH;
                end else begin
                  out_status <= ST_RELOC_OOR;
                end
              end
              default: begin
                // unused code: no action, plain ok
                out_status <= ST_OK;
              end
            endcase
          end
        end
        S_READ: begin
          out_status <= ST_OK;
          out_rbyte  <= byte_odd ? odd_q : even_q;
          state      <= S_IDLE;
        end
        S_PATCH: begin
          out_status <= ST_OK;
          out_rbyte  <= '0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.read_byte = out_rbyte;

endmodule

// ----- src/srp_ram.sv -----
// ----------------------------------------------------------------------------
// srp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module srp_ram #(
  parameter int ADDR_W = 19,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/srp_addr_gen.sv -----
// ----------------------------------------------------------------------------
// srp_addr_gen
// Physical address forming, bank split and range checks.
// ----------------------------------------------------------------------------
module srp_addr_gen import srp_pkg::*; (
  input  logic [SEG_W-1:0]   load_seg,
  input  logic [SEG_W-1:0]   psp_seg,
  input  logic [LIMIT_W-1:0] ram_limit,
  input  logic [BADDR_W-1:0] byte_address,
  input  logic [SEG_W-1:0]   rel_seg,
  input  logic [OFF_W-1:0]   rel_off,
  output srp_addr_t          addr
);

  logic [SEG_W-1:0]  tseg;
  logic [OFF_W-1:0]  hi_off;
  logic [WIDE_W-1:0] lo_pa;
  logic [WIDE_W-1:0] hi_pa;
  logic [WIDE_W-1:0] base_pa;
  logic [WIDE_W-1:0] byte_pa;
  logic [WIDE_W-1:0] limit_w;

  // below the limit and inside the physical image
  function automatic logic in_mem(logic [WIDE_W-1:0] a, logic [WIDE_W-1:0] lim);
    return (a < lim) && ((a >> ADDR_BITS) == '0);
  endfunction

  always_comb begin
    tseg    = load_seg + rel_seg;
    hi_off  = rel_off + OFF_W'(1);
    lo_pa   = WIDE_W'({tseg, 4'b0000}) + WIDE_W'(rel_off);
    hi_pa   = WIDE_W'({tseg, 4'b0000}) + WIDE_W'(hi_off);
    base_pa = WIDE_W'({psp_seg, 4'b0000});
    byte_pa = WIDE_W'(byte_address);
    limit_w = WIDE_W'(ram_limit);

    // low and high byte always differ in parity, so they fall in different banks
    addr.lo_row   = lo_pa[ADDR_BITS-1:1];
    addr.hi_row   = hi_pa[ADDR_BITS-1:1];
    addr.lo_odd   = lo_pa[0];
    addr.reloc_ok = (lo_pa >= base_pa) && (hi_pa >= base_pa) &&
                    in_mem(lo_pa, limit_w) && in_mem(hi_pa, limit_w);
    addr.byte_row = byte_pa[ADDR_BITS-1:1];
    addr.byte_odd = byte_pa[0];
    addr.byte_ok  = in_mem(byte_pa, limit_w);
  end

endmodule

// ----- src/srp_checker.sv -----
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks of the segment relocation patcher, bound to the top.
// ----------------------------------------------------------------------------
module srp_checker import srp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        status,
  input logic [BYTE_W-1:0] read_byte
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_byte))
    else $error("result changed while stalled");

  // no new item while a finished result is blocked
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("item taken while result blocked");

  // a failed item carries a zero read byte
  a_rbyte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> read_byte == '0)
    else $error("read byte set on failed item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind segment_relocation_patcher srp_checker u_srp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .read_byte (out_ch.read_byte)
);
